### design/aat_pkg.sv
// Package: shared types, constants and register map for the transformed-box block.
`default_nettype none

package aat_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 6;
    localparam int REG_IDX_W     = 3;
    localparam int ADDR_W        = REG_IDX_W + 2;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MIN_Y = 3'd1,
        REG_BOX_MIN_Z = 3'd2,
        REG_BOX_MAX_X = 3'd3,
        REG_BOX_MAX_Y = 3'd4,
        REG_BOX_MAX_Z = 3'd5
    } t_reg_idx;

    typedef logic signed [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word m11;
        t_word m12;
        t_word m13;
        t_word m21;
        t_word m22;
        t_word m23;
        t_word m31;
        t_word m32;
        t_word m33;
        t_word trans_x;
        t_word trans_y;
        t_word trans_z;
    } t_in;

    typedef struct packed {
        t_word world_min_x;
        t_word world_min_y;
        t_word world_min_z;
        t_word world_max_x;
        t_word world_max_y;
        t_word world_max_z;
    } t_out;

    // Per-stage load enables of the datapath pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

`default_nettype wire

### design/aat_axis.sv
// One world axis: product, per-row select, sum, and shift/offset/saturate stages.
`default_nettype none

module aat_axis
    import aat_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire t_pipe_en i_en,
    input  wire t_word    i_m0,
    input  wire t_word    i_m1,
    input  wire t_word    i_m2,
    input  wire t_word    i_trans,
    input  wire t_word    i_bmin0,
    input  wire t_word    i_bmin1,
    input  wire t_word    i_bmin2,
    input  wire t_word    i_bmax0,
    input  wire t_word    i_bmax1,
    input  wire t_word    i_bmax2,
    output t_word         o_min,
    output t_word         o_max
);

    localparam int PW   = 2 * WORD_BITS;
    localparam int SUMW = PW + 2;
    localparam int SW   = SUMW - FRAC_BITS + 1;

    logic signed [PW-1:0]   r_pa [3];
    logic signed [PW-1:0]   r_pb [3];
    logic signed [PW-1:0]   r_lo [3];
    logic signed [PW-1:0]   r_hi [3];
    logic signed [SUMW-1:0] r_sum_lo;
    logic signed [SUMW-1:0] r_sum_hi;
    t_word                  r_t1;
    t_word                  r_t2;
    t_word                  r_t3;
    t_word                  r_min;
    t_word                  r_max;

    logic signed [SW-1:0]   n_val_lo;
    logic signed [SW-1:0]   n_val_hi;
    t_word                  n_min;
    t_word                  n_max;

    function automatic t_word sat(input logic signed [SW-1:0] v);
        logic [SW-WORD_BITS:0] top;
        t_word                 res;
        top = v[SW-1:WORD_BITS-1];
        if ((top == '0) || (top == '1)) begin
            res = v[WORD_BITS-1:0];
        end else if (v[SW-1]) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    // Stage 1: both box extents times the matrix entry, each row.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_pa[0] <= PW'(i_bmin0) * PW'(i_m0);
            r_pb[0] <= PW'(i_bmax0) * PW'(i_m0);
            r_pa[1] <= PW'(i_bmin1) * PW'(i_m1);
            r_pb[1] <= PW'(i_bmax1) * PW'(i_m1);
            r_pa[2] <= PW'(i_bmin2) * PW'(i_m2);
            r_pb[2] <= PW'(i_bmax2) * PW'(i_m2);
            r_t1    <= i_trans;
        end
    end

    // Stage 2: smaller and larger product of each row.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int r = 0; r < 3; r++) begin
                if (r_pa[r] < r_pb[r]) begin
                    r_lo[r] <= r_pa[r];
                    r_hi[r] <= r_pb[r];
                end else begin
                    r_lo[r] <= r_pb[r];
                    r_hi[r] <= r_pa[r];
                end
            end
            r_t2 <= r_t1;
        end
    end

    // Stage 3: exact sums of the row extremes.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum_lo <= SUMW'(r_lo[0]) + SUMW'(r_lo[1]) + SUMW'(r_lo[2]);
            r_sum_hi <= SUMW'(r_hi[0]) + SUMW'(r_hi[1]) + SUMW'(r_hi[2]);
            r_t3     <= r_t2;
        end
    end

    // Stage 4: floor shift, add translation, saturate.
    always_comb begin
        n_val_lo = {r_sum_lo[SUMW-1], r_sum_lo[SUMW-1:FRAC_BITS]} + SW'(r_t3);
        n_val_hi = {r_sum_hi[SUMW-1], r_sum_hi[SUMW-1:FRAC_BITS]} + SW'(r_t3);
        n_min    = sat(n_val_lo);
        n_max    = sat(n_val_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

`default_nettype wire

### design/aabb_affine_transform.sv
// Top level: world-space bounding box of a configured model box under an affine matrix.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one affine matrix
//   per transfer: 3x3 linear part plus translation row, signed Q16.16.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns one world box
//   per matrix: per-axis minimum and maximum, saturated to 32 bits.
//   The model-space box lives in six APB registers (box_min_xyz, box_max_xyz)
//   at byte addresses 0x00..0x14; write them only while the block is idle.
//   Throughput: one matrix per cycle while the receiver does not stall, through the
//   four-stage datapath (multiply, per-row select, three-way sum, shift/offset/saturate).
//   Each axis needs only the smaller and larger product per row, so the
//   eight corners are never formed one by one; the hull is identical.
//   Reset (synchronous, active low) clears all stage valids and the box
//   registers to zero.
//   When the receiver stalls, the result holds on o_out_data; stages behind
//   it keep advancing into empty slots, and o_in_stall rises only once every
//   stage holds a transfer.
`default_nettype none

module aabb_affine_transform
    import aat_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_data,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Box registers.
    t_word r_box_min_x, r_box_min_y, r_box_min_z;
    t_word r_box_max_x, r_box_max_y, r_box_max_z;

    // Stage valids.
    logic r_v1, r_v2, r_v3, r_v4;

    t_pipe_en en;
    logic     wr_en;
    t_reg_idx reg_idx;
    t_word    wr_word;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_word = pwdata[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_min_z <= '0;
            r_box_max_x <= '0;
            r_box_max_y <= '0;
            r_box_max_z <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BOX_MIN_X: r_box_min_x <= wr_word;
                REG_BOX_MIN_Y: r_box_min_y <= wr_word;
                REG_BOX_MIN_Z: r_box_min_z <= wr_word;
                REG_BOX_MAX_X: r_box_max_x <= wr_word;
                REG_BOX_MAX_Y: r_box_max_y <= wr_word;
                REG_BOX_MAX_Z: r_box_max_z <= wr_word;
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BOX_MIN_X: prdata = APB_DATA_W'(r_box_min_x);
            REG_BOX_MIN_Y: prdata = APB_DATA_W'(r_box_min_y);
            REG_BOX_MIN_Z: prdata = APB_DATA_W'(r_box_min_z);
            REG_BOX_MAX_X: prdata = APB_DATA_W'(r_box_max_x);
            REG_BOX_MAX_Y: prdata = APB_DATA_W'(r_box_max_y);
            REG_BOX_MAX_Z: prdata = APB_DATA_W'(r_box_max_z);
            default:       prdata = '0;
        endcase
    end

    // A stage loads when it is empty or the stage after it advances, so
    // bubbles collapse under a stall and nothing is lost or repeated.
    always_comb begin
        en.s4 = !r_v4 || !i_out_stall;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_in_stall = !en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_in_valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    assign o_out_valid = r_v4;

    // World axis c draws on column c of the linear part; row r pairs with
    // model axis r of the box.
    aat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_m0    (i_in_data.m11),
        .i_m1    (i_in_data.m21),
        .i_m2    (i_in_data.m31),
        .i_trans (i_in_data.trans_x),
        .i_bmin0 (r_box_min_x),
        .i_bmin1 (r_box_min_y),
        .i_bmin2 (r_box_min_z),
        .i_bmax0 (r_box_max_x),
        .i_bmax1 (r_box_max_y),
        .i_bmax2 (r_box_max_z),
        .o_min   (o_out_data.world_min_x),
        .o_max   (o_out_data.world_max_x)
    );

    aat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_m0    (i_in_data.m12),
        .i_m1    (i_in_data.m22),
        .i_m2    (i_in_data.m32),
        .i_trans (i_in_data.trans_y),
        .i_bmin0 (r_box_min_x),
        .i_bmin1 (r_box_min_y),
        .i_bmin2 (r_box_min_z),
        .i_bmax0 (r_box_max_x),
        .i_bmax1 (r_box_max_y),
        .i_bmax2 (r_box_max_z),
        .o_min   (o_out_data.world_min_y),
        .o_max   (o_out_data.world_max_y)
    );

    aat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_m0    (i_in_data.m13),
        .i_m1    (i_in_data.m23),
        .i_m2    (i_in_data.m33),
        .i_trans (i_in_data.trans_z),
        .i_bmin0 (r_box_min_x),
        .i_bmin1 (r_box_min_y),
        .i_bmin2 (r_box_min_z),
        .i_bmax0 (r_box_max_x),
        .i_bmax1 (r_box_max_y),
        .i_bmax2 (r_box_max_z),
        .o_min   (o_out_data.world_min_z),
        .o_max   (o_out_data.world_max_z)
    );

endmodule

`default_nettype wire

### design/aat_checker.sv
// Port-level checker for the transformed-box block, bound to the top level.
`default_nettype none

module aat_checker
    import aat_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    // Stall the input only when the whole pipeline is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while pipeline has room");

    // An accepted matrix keeps a result on offer: either it reaches the last stage,
    // or it is blocked behind a full, stalled pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##4 o_out_valid)
        else $error("latency violated");

    // The world box never comes out inverted.
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.world_min_x <= o_out_data.world_max_x)
                     && (o_out_data.world_min_y <= o_out_data.world_max_y)
                     && (o_out_data.world_min_z <= o_out_data.world_max_z))
        else $error("world box minimum above maximum");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);

`default_nettype wire

### tb/sv/aabb_affine_transform_test.sv
// Self-checking testbench for the transformed-box block: random matrices, stalls, box settings.
`timescale 1ns / 1ps

module aabb_affine_transform_test;
    import aat_pkg::*;

    localparam int     FRAC    = FRAC_BITS_DEF;
    localparam int     LATENCY = 4;
    localparam int     PHASES  = 8;
    localparam int     PHASE_N = 138;
    localparam t_word  ONE     = 32'sh0001_0000;
    localparam t_word  WMAX    = 32'sh7fff_ffff;
    localparam t_word  WMIN    = 32'sh8000_0000;

    typedef enum int {BOX_ORDERED, BOX_WIDE, BOX_EXTREME, BOX_SWAPPED, BOX_FLAT} t_box_kind;

    // Keeps a shadow copy of the six box registers, predicts the world box for each
    // matrix transfer and compares the block's results against that prediction.
    class world_box_tracker;
        t_word       box_reg[NUM_REGS];
        t_out        pending_boxes[$];
        int unsigned errors;
        int unsigned shown;

        function void clear_regs();
            foreach (box_reg[i]) box_reg[i] = '0;
        endfunction

        function void write_reg(int idx, t_word v);
            if (idx >= 0 && idx < NUM_REGS) box_reg[idx] = v;
        endfunction

        // One coordinate of one corner: exact dot product, floor shift, offset, saturate.
        function t_word corner_axis(t_word p[3], t_word col[3], t_word offs);
            logic signed [79:0] acc, wa, wb, top_v, bot_v;
            top_v = WMAX;
            bot_v = WMIN;
            acc = '0;
            for (int r = 0; r < 3; r++) begin
                wa = p[r];
                wb = col[r];
                acc = acc + wa * wb;
            end
            wa = offs;
            acc = (acc >>> FRAC) + wa;
            if (acc > top_v) return WMAX;
            if (acc < bot_v) return WMIN;
            return acc[WORD_BITS-1:0];
        endfunction

        function t_out transform_box(t_in m);
            t_word mat[3][3];
            t_word offs[3];
            t_word p[3];
            t_word col[3];
            t_word lo[3];
            t_word hi[3];
            t_word v;
            t_out  r;
            mat[0] = '{m.m11, m.m12, m.m13};
            mat[1] = '{m.m21, m.m22, m.m23};
            mat[2] = '{m.m31, m.m32, m.m33};
            offs   = '{m.trans_x, m.trans_y, m.trans_z};
            // Walk all eight corners; each axis picks min or max from its own bit.
            for (int k = 0; k < 8; k++) begin
                p[0] = (k & 1) ? box_reg[REG_BOX_MAX_X] : box_reg[REG_BOX_MIN_X];
                p[1] = (k & 2) ? box_reg[REG_BOX_MAX_Y] : box_reg[REG_BOX_MIN_Y];
                p[2] = (k & 4) ? box_reg[REG_BOX_MAX_Z] : box_reg[REG_BOX_MIN_Z];
                for (int c = 0; c < 3; c++) begin
                    for (int r = 0; r < 3; r++) col[r] = mat[r][c];
                    v = corner_axis(p, col, offs[c]);
                    if (k == 0 || v < lo[c]) lo[c] = v;
                    if (k == 0 || v > hi[c]) hi[c] = v;
                end
            end
            r.world_min_x = lo[0];
            r.world_min_y = lo[1];
            r.world_min_z = lo[2];
            r.world_max_x = hi[0];
            r.world_max_y = hi[1];
            r.world_max_z = hi[2];
            return r;
        endfunction

        function void note_matrix(t_in m);
            pending_boxes = {pending_boxes, transform_box(m)};
        endfunction

        function void report(string msg);
            if (shown < 10) $display("%t: %s", $realtime, msg);
            shown++;
            errors++;
        endfunction

        function void check_box(t_out got);
            t_out  want;
            t_word w, g;
            string names[6];
            names = '{"world_min_x", "world_min_y", "world_min_z",
                      "world_max_x", "world_max_y", "world_max_z"};
            if (pending_boxes.size() == 0) begin
                report($sformatf("unexpected result transfer 0x%h", got));
                return;
            end
            want = pending_boxes.pop_front();
            for (int f = 0; f < 6; f++) begin
                w = want[(5-f)*WORD_BITS +: WORD_BITS];
                g = got[(5-f)*WORD_BITS +: WORD_BITS];
                if (g !== w)
                    report($sformatf("%s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                                     names[f], w, w, g, g));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Calm flags: when set, that side neither gaps nor stalls.
    bit in_calm;
    bit out_calm;

    world_box_tracker sb;

    aabb_affine_transform i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Mostly small Q16.16 values (within +/-4.0), plus full-range words and corner values.
    function automatic t_word rand_word();
        t_word picks[6];
        picks = '{WMAX, WMIN, '0, -32'sd1, ONE, -ONE};
        case ($urandom_range(9, 0))
            0:       return picks[$urandom_range(5, 0)];
            1, 2, 3: return $urandom;
            default: return t_word'(int'($urandom_range(524288, 0)) - 262144);
        endcase
    endfunction

    function automatic t_in rand_matrix();
        t_in m;
        for (int f = 0; f < 12; f++) m[f*WORD_BITS +: WORD_BITS] = rand_word();
        return m;
    endfunction

    function automatic t_in diag_matrix(t_word d, t_word tx, t_word ty, t_word tz);
        return t_in'{d, 0, 0, 0, d, 0, 0, 0, d, tx, ty, tz};
    endfunction

    function automatic t_in fill_matrix(t_word v);
        return t_in'{v, v, v, v, v, v, v, v, v, v, v, v};
    endfunction

    // Register write: setup phase, then access phase until pready; shadow on completion.
    task automatic cfg_write(int idx, t_word val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(idx * 4);
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_box(t_word nx, t_word ny, t_word nz, t_word xx, t_word xy, t_word xz);
        cfg_write(REG_BOX_MIN_X, nx);
        cfg_write(REG_BOX_MIN_Y, ny);
        cfg_write(REG_BOX_MIN_Z, nz);
        cfg_write(REG_BOX_MAX_X, xx);
        cfg_write(REG_BOX_MAX_Y, xy);
        cfg_write(REG_BOX_MAX_Z, xz);
    endtask

    // Draw a fresh box per axis of the requested shape.
    task automatic load_box(t_box_kind kind);
        t_word a, b, lo, hi;
        for (int ax = 0; ax < 3; ax++) begin
            a = rand_word();
            b = rand_word();
            case (kind)
                BOX_ORDERED: begin
                    a  = t_word'(int'($urandom_range(1048576, 0)) - 524288);
                    b  = t_word'(int'($urandom_range(1048576, 0)) - 524288);
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                end
                BOX_WIDE: begin
                    lo = $urandom;
                    hi = $urandom;
                end
                BOX_EXTREME: begin
                    lo = WMIN;
                    hi = WMAX;
                end
                BOX_SWAPPED: begin
                    lo = (a < b) ? b : a;
                    hi = (a < b) ? a : b;
                end
                default: begin
                    lo = a;
                    hi = a;
                end
            endcase
            cfg_write(REG_BOX_MIN_X + ax, lo);
            cfg_write(REG_BOX_MAX_X + ax, hi);
        end
        // Writes past the last register must leave the box alone.
        if ($urandom_range(1, 0)) cfg_write(NUM_REGS + $urandom_range(1, 0), $urandom);
    endtask

    // Offer one matrix after a random gap and hold it until the transfer happens.
    task automatic send_matrix(t_in m);
        int gap;
        gap = in_calm ? 0 : $urandom_range(15, 0);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = m;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.note_matrix(m);
    endtask

    // Drop valid, wait for every predicted box, then let the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_boxes.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // Result side: stall for a random count per transfer, then accept and check.
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            n = out_calm ? 0 : $urandom_range(15, 0);
            if (n > 0) begin
                i_out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            sb.check_box(o_out_data);
        end
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #(10_000_000);
        $display("aabb_affine_transform_test failed");
        $finish;
    end

    initial begin
        sb = new;
        sb.clear_regs();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_calm    = 1'b0;
        out_calm   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Box still zero after reset: the result collapses to the translation.
        send_matrix(fill_matrix(WMAX));
        send_matrix(fill_matrix(WMIN));
        drain();

        // Ordinary box, min below max on every axis.
        set_box(-ONE, -2 * ONE, -3 * ONE, 2 * ONE, ONE / 2, 4 * ONE);
        send_matrix(diag_matrix(ONE, 0, 0, 0));
        send_matrix(diag_matrix(ONE, ONE + ONE / 2, -(2 * ONE + ONE / 2), 100 * ONE));
        send_matrix(t_in'{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0});
        send_matrix(diag_matrix(-3 * ONE, ONE, -ONE, 0));
        // Single-LSB entries exercise the round toward minus infinity.
        send_matrix(fill_matrix(-32'sd1));
        send_matrix(fill_matrix(32'sd1));
        send_matrix(t_in'{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN,
                          WMAX, WMIN, WMAX, WMIN, WMAX, WMIN});
        send_matrix(fill_matrix(WMAX));
        send_matrix(t_in'{0, 0, 0, 0, 0, 0, 0, 0, 0, WMAX, WMIN, -32'sd1});
        drain();

        // Full-range box: nearly every corner coordinate saturates.
        set_box(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX);
        send_matrix(diag_matrix(ONE, 0, 0, 0));
        send_matrix(fill_matrix(WMAX));
        send_matrix(fill_matrix(WMIN));
        send_matrix(diag_matrix(ONE, WMAX, WMAX, WMAX));
        send_matrix(fill_matrix(32'sd1));
        drain();

        // Minimum above maximum on every axis; stray writes past the map must be ignored.
        set_box(5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE, -5 * ONE);
        cfg_write(NUM_REGS, WMAX);
        cfg_write(NUM_REGS + 1, WMIN);
        send_matrix(diag_matrix(ONE, 0, 0, 0));
        send_matrix(t_in'{0, -ONE, ONE / 2, ONE, 0, 0, 0, ONE / 4, -2 * ONE, ONE, 0, -ONE});
        send_matrix(rand_matrix());
        send_matrix(rand_matrix());
        drain();

        // Random phases: a new box shape each time, alternating calm and heavy idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            in_calm  = (ph % 3 == 0);
            out_calm = (ph % 3 == 0) || (ph == 4);
            load_box(t_box_kind'(ph % 5));
            for (int i = 0; i < PHASE_N; i++) send_matrix(rand_matrix());
            drain();
        end

        if (sb.errors == 0) begin
            $display("aabb_affine_transform_test passed");
        end else begin
            $display("aabb_affine_transform_test failed");
        end
        $finish;
    end

endmodule
